[hw/rtl/psa_pkg.sv]
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the priority scheduler with aging: job and
// result payloads, slot table word, and controller command and status groups.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int MAX_JOBS_DFLT = 16;
   localparam int ID_W          = 8;
   localparam int ARR_W         = 16;
   localparam int BURST_W       = 16;
   localparam int PRIO_W        = 8;
   localparam int ORD_W         = 6;
   localparam int TIME_W        = 23;
   localparam int STEP_W        = 4;

   localparam logic [STEP_W-1:0] AGING_STEP_RST = STEP_W'(1);

   typedef struct packed {
      logic [ID_W-1:0]    job_id;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  start_priority;
      logic               last_job;
   } req_job_type;

   typedef struct packed {
      logic [ID_W-1:0]    out_job_id;
      logic [TIME_W-1:0]  start_time;
      logic [BURST_W-1:0] run_length;
      logic [TIME_W-1:0]  wait_time;
      logic [TIME_W-1:0]  turn_time;
      logic [PRIO_W-1:0]  aged_priority;
      logic               last_result;
   } rsp_result_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [ORD_W-1:0]   order;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic load_wr;
      logic proc_vld;
      logic round_clr;
      logic dispatch;
      logic last_flag;
      logic jump;
      logic batch_clr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic have_best;
      logic have_next;
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/priority_scheduler_with_aging_core.sv]
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_core
// Jobs load one per cycle while req_ready is high; the job marked last_job
// starts a non-preemptive priority schedule from time 0. Every round scans
// the slot table once through its single read port, one entry per cycle,
// admitting, aging and comparing as it goes, then makes a decision. Each
// round either dispatches one job (one result) or jumps idle time to the
// next arrival, so a batch of N loaded jobs takes between N and 2N rounds.
// A dispatch waits only while the previous result still sits unaccepted in
// the output register. No input is taken during scheduling; csr writes to
// aging_step are taken at any time.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_core #(
   parameter int MAX_JOBS = psa_pkg::MAX_JOBS_DFLT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [psa_pkg::STEP_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  psa_pkg::req_job_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output psa_pkg::rsp_result_type     rsp_data
);

   import psa_pkg::*;

   localparam int IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

   ctrl_cmd_type    cmd;
   dp_status_type   status;
   logic [IdxW-1:0] load_addr;
   logic [IdxW-1:0] rd_addr;
   logic [IdxW-1:0] proc_addr;

   psa_ctrl #(
      .MAX_JOBS (MAX_JOBS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_job),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .load_addr (load_addr),
      .rd_addr   (rd_addr),
      .proc_addr (proc_addr)
   );

   psa_dp #(
      .MAX_JOBS (MAX_JOBS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .load_addr   (load_addr),
      .rd_addr     (rd_addr),
      .proc_addr   (proc_addr),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

[hw/rtl/psa_ram.sv]
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/psa_ctrl.sv]
// ----------------------------------------------------------------------------
// psa_ctrl
// Scheduler controller: load sequencing, table scan addressing, per-round
// dispatch / jump decision and batch bookkeeping.
// ----------------------------------------------------------------------------
module psa_ctrl #(
   parameter  int MAX_JOBS = 16,
   localparam int IdxW     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
   localparam int CntW     = $clog2(MAX_JOBS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   input  psa_pkg::dp_status_type  status,
   output psa_pkg::ctrl_cmd_type   cmd,
   output logic [IdxW-1:0]         load_addr,
   output logic [IdxW-1:0]         rd_addr,
   output logic [IdxW-1:0]         proc_addr
);

   import psa_pkg::*;

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]      state_ff,    state_in;
   logic [CntW-1:0] job_cnt_ff,  job_cnt_in;
   logic [CntW-1:0] fin_ff,      fin_in;
   logic [CntW-1:0] rd_cnt_ff,   rd_cnt_in;
   logic            proc_vld_ff, proc_vld_in;
   logic [IdxW-1:0] proc_idx_ff, proc_idx_in;
   logic            last_disp;

   always_comb begin
      state_in    = state_ff;
      job_cnt_in  = job_cnt_ff;
      fin_in      = fin_ff;
      rd_cnt_in   = rd_cnt_ff;
      proc_vld_in = 1'b0;
      proc_idx_in = proc_idx_ff;
      cmd         = '0;
      last_disp   = ((fin_ff + CntW'(1)) == job_cnt_ff);
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (job_cnt_ff < CntW'(MAX_JOBS)) begin
                  cmd.load_wr = 1'b1;
                  job_cnt_in  = job_cnt_ff + CntW'(1);
               end
               if (req_last) begin
                  cmd.round_clr = 1'b1;
                  rd_cnt_in     = '0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.proc_vld = proc_vld_ff;
            if (rd_cnt_ff < job_cnt_ff) begin
               proc_vld_in = 1'b1;
               proc_idx_in = rd_cnt_ff[IdxW-1:0];
               rd_cnt_in   = rd_cnt_ff + CntW'(1);
            end
            if (proc_vld_ff && (rd_cnt_ff == job_cnt_ff)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.have_best) begin
               if (status.out_free) begin
                  cmd.dispatch  = 1'b1;
                  cmd.last_flag = last_disp;
                  if (last_disp) begin
                     cmd.batch_clr = 1'b1;
                     job_cnt_in    = '0;
                     fin_in        = '0;
                     state_in      = ST_LOAD;
                  end else begin
                     fin_in        = fin_ff + CntW'(1);
                     cmd.round_clr = 1'b1;
                     rd_cnt_in     = '0;
                     state_in      = ST_SCAN;
                  end
               end
            end else if (status.have_next) begin
               cmd.jump      = 1'b1;
               cmd.round_clr = 1'b1;
               rd_cnt_in     = '0;
               state_in      = ST_SCAN;
            end else begin
               cmd.batch_clr = 1'b1;
               job_cnt_in    = '0;
               fin_in        = '0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         job_cnt_ff  <= '0;
         fin_ff      <= '0;
         rd_cnt_ff   <= '0;
         proc_vld_ff <= 1'b0;
         proc_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         job_cnt_ff  <= job_cnt_in;
         fin_ff      <= fin_in;
         rd_cnt_ff   <= rd_cnt_in;
         proc_vld_ff <= proc_vld_in;
         proc_idx_ff <= proc_idx_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign load_addr = job_cnt_ff[IdxW-1:0];
   assign rd_addr   = rd_cnt_ff[IdxW-1:0];
   assign proc_addr = proc_idx_ff;

endmodule

[hw/rtl/psa_dp.sv]
// ----------------------------------------------------------------------------
// psa_dp
// Scheduler datapath: slot table RAM, ready/done flags, scheduling clock,
// admit counter, per-entry admit/age/select stage and result register.
// ----------------------------------------------------------------------------
module psa_dp #(
   parameter  int MAX_JOBS = 16,
   localparam int IdxW     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [psa_pkg::STEP_W-1:0]        csr_wr_data,
   input  psa_pkg::req_job_type              req_data,
   input  psa_pkg::ctrl_cmd_type             cmd,
   input  logic [IdxW-1:0]                   load_addr,
   input  logic [IdxW-1:0]                   rd_addr,
   input  logic [IdxW-1:0]                   proc_addr,
   output psa_pkg::dp_status_type            status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output psa_pkg::rsp_result_type           rsp_data
);

   import psa_pkg::*;

   logic [STEP_W-1:0]   step_ff,      step_in;
   logic [MAX_JOBS-1:0] ready_ff,     ready_in;
   logic [MAX_JOBS-1:0] done_ff,      done_in;
   logic [TIME_W-1:0]   time_ff,      time_in;
   logic [ORD_W-1:0]    admit_ff,     admit_in;
   logic                best_vld_ff,  best_vld_in;
   logic [IdxW-1:0]     best_idx_ff,  best_idx_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic [ORD_W-1:0]    best_ord_ff,  best_ord_in;
   logic [ID_W-1:0]     best_id_ff,   best_id_in;
   logic [BURST_W-1:0]  best_burst_ff, best_burst_in;
   logic [TIME_W-1:0]   best_wait_ff, best_wait_in;
   logic                next_vld_ff,  next_vld_in;
   logic [ARR_W-1:0]    next_arr_ff,  next_arr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_result_type      rsp_data_ff,  rsp_data_in;

   logic [SLOT_W-1:0]   ram_rd_data;
   logic [SLOT_W-1:0]   ram_wr_data;
   logic [IdxW-1:0]     ram_wr_addr;
   slot_type            cur;
   slot_type            upd;
   logic [TIME_W-1:0]   arr_ext;
   logic                cur_rdy;
   logic                cur_done;
   logic                adm;
   logic                rdy_new;
   logic                age;
   logic [PRIO_W-1:0]   step_ext;
   logic                better;
   logic                nxt_better;
   logic                out_free;

   psa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_JOBS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.load_wr | cmd.proc_vld),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // admit, age and compare one table entry
   always_comb begin
      cur       = slot_type'(ram_rd_data);
      arr_ext   = TIME_W'(cur.arrival);
      cur_rdy   = ready_ff[proc_addr];
      cur_done  = done_ff[proc_addr];
      adm       = !cur_rdy && !cur_done && (arr_ext <= time_ff);
      rdy_new   = cur_rdy | adm;
      step_ext  = PRIO_W'(step_ff);
      upd       = cur;
      if (adm) begin
         upd.order = admit_ff;
      end
      age = rdy_new && (arr_ext < time_ff);
      if (age) begin
         upd.prio = (cur.prio > step_ext) ? (cur.prio - step_ext) : '0;
      end
      better = rdy_new && (!best_vld_ff || (upd.prio < best_prio_ff) ||
               ((upd.prio == best_prio_ff) && (upd.order < best_ord_ff)));
      nxt_better = !rdy_new && !cur_done &&
                   (!next_vld_ff || (cur.arrival < next_arr_ff));
   end

   always_comb begin
      if (cmd.load_wr) begin
         ram_wr_addr = load_addr;
         ram_wr_data = SLOT_W'({req_data.job_id, req_data.arrival, req_data.burst,
                                req_data.start_priority, ORD_W'(0)});
      end else begin
         ram_wr_addr = proc_addr;
         ram_wr_data = SLOT_W'(upd);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      step_in       = csr_wr_en ? csr_wr_data : step_ff;
      ready_in      = ready_ff;
      done_in       = done_ff;
      time_in       = time_ff;
      admit_in      = admit_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_ord_in   = best_ord_ff;
      best_id_in    = best_id_ff;
      best_burst_in = best_burst_ff;
      best_wait_in  = best_wait_ff;
      next_vld_in   = next_vld_ff;
      next_arr_in   = next_arr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (cmd.proc_vld) begin
         ready_in[proc_addr] = rdy_new;
         if (adm) begin
            admit_in = admit_ff + ORD_W'(1);
         end
         if (better) begin
            best_vld_in   = 1'b1;
            best_idx_in   = proc_addr;
            best_prio_in  = upd.prio;
            best_ord_in   = upd.order;
            best_id_in    = cur.id;
            best_burst_in = cur.burst;
            best_wait_in  = time_ff - arr_ext;
         end
         if (nxt_better) begin
            next_vld_in = 1'b1;
            next_arr_in = cur.arrival;
         end
      end

      if (cmd.dispatch) begin
         ready_in[best_idx_ff]     = 1'b0;
         done_in[best_idx_ff]      = 1'b1;
         time_in                   = time_ff + TIME_W'(best_burst_ff);
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_job_id    = best_id_ff;
         rsp_data_in.start_time    = time_ff;
         rsp_data_in.run_length    = best_burst_ff;
         rsp_data_in.wait_time     = best_wait_ff;
         rsp_data_in.turn_time     = best_wait_ff + TIME_W'(best_burst_ff);
         rsp_data_in.aged_priority = best_prio_ff;
         rsp_data_in.last_result   = cmd.last_flag;
      end

      if (cmd.jump) begin
         time_in = TIME_W'(next_arr_ff);
      end

      if (cmd.round_clr) begin
         best_vld_in = 1'b0;
         next_vld_in = 1'b0;
      end

      if (cmd.batch_clr) begin
         ready_in    = '0;
         done_in     = '0;
         time_in     = '0;
         admit_in    = '0;
         best_vld_in = 1'b0;
         next_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= AGING_STEP_RST;
         ready_ff     <= '0;
         done_ff      <= '0;
         time_ff      <= '0;
         admit_ff     <= '0;
         best_vld_ff  <= 1'b0;
         next_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         ready_ff     <= ready_in;
         done_ff      <= done_in;
         time_ff      <= time_in;
         admit_ff     <= admit_in;
         best_vld_ff  <= best_vld_in;
         next_vld_ff  <= next_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_ord_ff   <= best_ord_in;
      best_id_ff    <= best_id_in;
      best_burst_ff <= best_burst_in;
      best_wait_ff  <= best_wait_in;
      next_arr_ff   <= next_arr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign status.have_best = best_vld_ff;
   assign status.have_next = next_vld_ff;
   assign status.out_free  = out_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule
